>>> design/adsc_pkg.sv
// ----------------------------------------------------------------------------
// adsc_pkg
// Shared types, constants and helpers of the audio DAC serial config sequencer.
// ----------------------------------------------------------------------------
package adsc_pkg;

  // serial word geometry
  localparam int WORD_BITS    = 16;
  localparam int CHANNEL_BITS = 3;
  localparam int BIT_IDX_W    = $clog2(WORD_BITS + 1);
  localparam int BIT_SEL_W    = $clog2(WORD_BITS);

  // tick counter and configuration widths
  localparam int TICK_W  = 24;
  localparam int SHORT_W = 16;
  localparam int CFG_W   = 24;
  localparam int ADDR_W  = 3;

  // fixed serial words
  localparam logic [WORD_BITS-1:0] FIRST_WORD = WORD_BITS'(16'h0520);
  localparam logic [WORD_BITS-1:0] RATE_WORD  = WORD_BITS'(16'h0608);
  localparam int                   RATE_LSB   = 6;

  // pin vector layout: bit0 reset, bit1 latch, bit2 clock, bit3 data
  localparam logic [3:0] PIN_RST  = 4'b0001;
  localparam logic [3:0] PIN_LAT  = 4'b0010;
  localparam logic [3:0] PIN_CLK  = 4'b0100;
  localparam logic [3:0] PIN_DAT  = 4'b1000;
  localparam logic [3:0] PIN_NONE = 4'b0000;
  localparam logic [3:0] PIN_ALL  = 4'b1111;

  // register indexes of the configuration port
  localparam logic [ADDR_W-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_RESET_WAIT  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_BIT_TICKS   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_LATCH_TICKS = 3'd3;
  localparam logic [ADDR_W-1:0] REG_RESET_PULSE = 3'd4;

  // register reset values
  localparam logic [TICK_W-1:0]  RESET_LOW_DEF   = 24'd200000;
  localparam logic [TICK_W-1:0]  RESET_WAIT_DEF  = 24'd200000;
  localparam logic [SHORT_W-1:0] BIT_TICKS_DEF   = 16'd10;
  localparam logic [SHORT_W-1:0] LATCH_TICKS_DEF = 16'd10;
  localparam logic [TICK_W-1:0]  RESET_PULSE_DEF = 24'd100000;

  // command codes carried in the action field
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // sample rate selections
  localparam logic [1:0] RATE_32K  = 2'd0;
  localparam logic [1:0] RATE_44K1 = 2'd1;
  localparam logic [1:0] RATE_48K  = 2'd2;
  localparam logic [1:0] RATE_BAD  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_WAIT,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_LATCH,
    PH_RSTP
  } phase_t;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [TICK_W-1:0]  reset_low_ticks;
    logic [TICK_W-1:0]  reset_wait_ticks;
    logic [SHORT_W-1:0] bit_ticks;
    logic [SHORT_W-1:0] latch_ticks;
    logic [TICK_W-1:0]  reset_pulse_ticks;
  } cfg_regs_t;

  // sequencer state
  typedef struct packed {
    phase_t                  phase;
    logic [TICK_W-1:0]       tick_count;
    logic [BIT_IDX_W-1:0]    bit_index;
    logic [WORD_BITS-1:0]    shift_word;
    logic [3:0]              pins;
    logic [CHANNEL_BITS-1:0] target;
    logic                    pending;
    logic [1:0]              rate_code;
    logic                    err;
  } seq_state_t;

  // a zero delay counts as one tick
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // sample rate selection to the two-bit code of the rate word
  function automatic logic [1:0] rate_to_code(input logic [1:0] rate);
    logic [1:0] code;
    case (rate)
      RATE_32K:  code = 2'd2;
      RATE_44K1: code = 2'd0;
      RATE_48K:  code = 2'd1;
      default:   code = 2'd1;
    endcase
    return code;
  endfunction

endpackage

>>> design/adsc_step.sv
// ----------------------------------------------------------------------------
// adsc_step
// Next-state logic of the pin sequencer for one tick or command.
// ----------------------------------------------------------------------------
module adsc_step import adsc_pkg::*; (
  input  seq_state_t              cur,
  input  cfg_regs_t               cfg,
  input  logic [1:0]              action,
  input  logic [CHANNEL_BITS-1:0] channel,
  input  logic [1:0]              sample_rate,
  output seq_state_t              nxt,
  output logic                    done
);

  logic                 is_idle;
  logic                 start_cmd;
  logic                 reset_cmd;
  logic                 expire;
  logic [BIT_IDX_W-1:0] idx_dec;
  logic [BIT_IDX_W-1:0] idx_dec2;
  logic                 last_bit;
  logic [TICK_W-1:0]    bit_load;
  logic [TICK_W-1:0]    latch_load;
  logic [WORD_BITS-1:0] rate_word;
  phase_t               phase_nxt;

  // command decode and counter expiry
  assign is_idle    = (cur.phase == PH_IDLE);
  assign start_cmd  = is_idle && (action == ACT_START);
  assign reset_cmd  = is_idle && (action == ACT_RESET);
  assign expire     = !is_idle && (cur.tick_count == TICK_W'(1));
  assign idx_dec    = cur.bit_index - BIT_IDX_W'(1);
  assign idx_dec2   = cur.bit_index - BIT_IDX_W'(2);
  assign last_bit   = (idx_dec == '0);
  assign bit_load   = at_least_one(TICK_W'(cfg.bit_ticks));
  assign latch_load = at_least_one(TICK_W'(cfg.latch_ticks));
  assign rate_word  = RATE_WORD | (WORD_BITS'(cur.rate_code) << RATE_LSB);

  // next phase
  always_comb begin
    phase_nxt = cur.phase;
    if (start_cmd) begin
      phase_nxt = PH_LOW;
    end else if (reset_cmd) begin
      phase_nxt = PH_RSTP;
    end else if (expire) begin
      case (cur.phase)
        PH_LOW:      phase_nxt = PH_WAIT;
        PH_WAIT:     phase_nxt = PH_BIT_LOW;
        PH_BIT_LOW:  phase_nxt = PH_BIT_HIGH;
        PH_BIT_HIGH: phase_nxt = last_bit ? PH_LATCH : PH_BIT_LOW;
        PH_LATCH:    phase_nxt = cur.pending ? PH_BIT_LOW : PH_IDLE;
        PH_RSTP:     phase_nxt = PH_IDLE;
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign done = expire && (((cur.phase == PH_LATCH) && !cur.pending) ||
                           (cur.phase == PH_RSTP));

  // counters, shift word and pin levels
  always_comb begin
    nxt       = cur;
    nxt.phase = phase_nxt;
    if (!is_idle) begin
      nxt.tick_count = cur.tick_count - TICK_W'(1);
    end
    if (start_cmd) begin
      nxt.target     = channel;
      nxt.rate_code  = rate_to_code(sample_rate);
      nxt.err        = (sample_rate == RATE_BAD);
      nxt.pending    = (sample_rate != RATE_BAD);
      nxt.pins       = PIN_NONE;
      nxt.tick_count = at_least_one(cfg.reset_low_ticks);
    end else if (reset_cmd) begin
      nxt.target     = channel;
      nxt.pins       = cur.pins & ~PIN_RST;
      nxt.tick_count = at_least_one(cfg.reset_pulse_ticks);
    end else if (expire) begin
      case (cur.phase)
        PH_LOW: begin
          nxt.pins       = PIN_ALL;
          nxt.tick_count = at_least_one(cfg.reset_wait_ticks);
        end
        PH_WAIT: begin
          nxt.shift_word = FIRST_WORD;
          nxt.bit_index  = BIT_IDX_W'(WORD_BITS);
          nxt.pins       = PIN_RST | PIN_LAT | (FIRST_WORD[WORD_BITS-1] ? PIN_DAT : PIN_NONE);
          nxt.tick_count = bit_load;
        end
        PH_BIT_LOW: begin
          nxt.pins       = cur.pins | PIN_CLK;
          nxt.tick_count = bit_load;
        end
        PH_BIT_HIGH: begin
          nxt.bit_index = idx_dec;
          if (!last_bit) begin
            nxt.pins = PIN_RST | PIN_LAT |
                       (cur.shift_word[idx_dec2[BIT_SEL_W-1:0]] ? PIN_DAT : PIN_NONE);
            nxt.tick_count = bit_load;
          end else begin
            nxt.pins       = (cur.pins | PIN_DAT) & ~PIN_LAT;
            nxt.tick_count = latch_load;
          end
        end
        PH_LATCH: begin
          nxt.pins = cur.pins | PIN_LAT;
          if (cur.pending) begin
            nxt.pending    = 1'b0;
            nxt.shift_word = rate_word;
            nxt.bit_index  = BIT_IDX_W'(WORD_BITS);
            nxt.pins       = PIN_RST | PIN_LAT | (rate_word[WORD_BITS-1] ? PIN_DAT : PIN_NONE);
            nxt.tick_count = bit_load;
          end
        end
        PH_RSTP: begin
          nxt.pins = cur.pins | PIN_RST;
        end
        default: begin
          nxt.pins = cur.pins;
        end
      endcase
    end
  end

endmodule

>>> design/audio_dac_serial_config_sequencer.sv
// ----------------------------------------------------------------------------
// audio_dac_serial_config_sequencer
// Tick-driven sequencer for the reset, latch, clock and data pins of a DAC.
// ----------------------------------------------------------------------------
// Every input transfer is one tick or a command and yields exactly one output
// transfer with the pin levels and status after that tick. The block takes one
// item per clock unless the output stalls: the phase, tick counter and shift
// word are computed combinationally into one output register, so in_tready is
// high whenever that register is empty or being taken in the same cycle. Each
// result is offered in the cycle after its input transfer. A start command
// runs the all-low and all-high reset phases, shifts 0x0520 MSB first, pulses
// latch, then sends 0x0608 with the rate code in bits 7..6 (skipped with
// rate_error set for an unsupported rate). A reset command pulses only the
// reset pin. Commands that arrive while a sequence runs count as plain ticks.
module audio_dac_serial_config_sequencer import adsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [2:0] channel, [4:3] sample_rate
  input  logic [1:0]        in_tuser,   // [1:0] action
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata   // [0] pin_reset, [1] pin_latch,
                                        // [2] pin_clock, [3] pin_data,
                                        // [6:4] select, [7] busy_res,
                                        // [8] done_res, [9] rate_error
);

  cfg_regs_t   cfg_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic        done;
  logic        in_xfer;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks   <= RESET_LOW_DEF;
      cfg_r.reset_wait_ticks  <= RESET_WAIT_DEF;
      cfg_r.bit_ticks         <= BIT_TICKS_DEF;
      cfg_r.latch_ticks       <= LATCH_TICKS_DEF;
      cfg_r.reset_pulse_ticks <= RESET_PULSE_DEF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RESET_LOW:   cfg_r.reset_low_ticks   <= cfg_wdata[TICK_W-1:0];
        REG_RESET_WAIT:  cfg_r.reset_wait_ticks  <= cfg_wdata[TICK_W-1:0];
        REG_BIT_TICKS:   cfg_r.bit_ticks         <= cfg_wdata[SHORT_W-1:0];
        REG_LATCH_TICKS: cfg_r.latch_ticks       <= cfg_wdata[SHORT_W-1:0];
        REG_RESET_PULSE: cfg_r.reset_pulse_ticks <= cfg_wdata[TICK_W-1:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // handshake: the output register frees up when empty or taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // one tick of the sequencer
  adsc_step u_step (
    .cur         (state_r),
    .cfg         (cfg_r),
    .action      (in_tuser),
    .channel     (in_tdata[CHANNEL_BITS-1:0]),
    .sample_rate (in_tdata[CHANNEL_BITS+1:CHANNEL_BITS]),
    .nxt         (state_nxt),
    .done        (done)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.tick_count <= '0;
      state_r.bit_index  <= '0;
      state_r.shift_word <= '0;
      state_r.pins       <= PIN_ALL;
      state_r.target     <= '0;
      state_r.pending    <= 1'b0;
      state_r.rate_code  <= '0;
      state_r.err        <= 1'b0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // result packing
  assign out_data_nxt = {6'd0, state_nxt.err, done, (state_nxt.phase != PH_IDLE),
                         state_nxt.target, state_nxt.pins};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/adsc_checker.sv
// ----------------------------------------------------------------------------
// adsc_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module adsc_checker import adsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [15:0]       out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output register");

  // every input transfer shows up as a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer produced no result");

  // a completing tick reports the block as no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> !out_tdata[7])
    else $error("done reported while still busy");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind audio_dac_serial_config_sequencer adsc_checker u_adsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/audio_dac_serial_config_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dac_serial_config_sequencer_test
// Drives tick and command transfers into the DAC pin sequencer and checks
// every result transfer against a cycle-free pin sequence predictor. A short
// table of directed items runs first, then random phases under several
// register settings with varying stalls on both streams.
// ----------------------------------------------------------------------------
module audio_dac_serial_config_sequencer_test;
  import adsc_pkg::*;

  // unused action code, the block treats it as a plain tick
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 250;

  // input item fields
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] channel;
    logic [1:0] rate;
  } in_item_t;

  // result layout of out_tdata, lowest bit last
  typedef struct packed {
    logic [5:0] pad;
    logic       rate_error;
    logic       done_res;
    logic       busy_res;
    logic [2:0] sel;
    logic       pin_data;
    logic       pin_clock;
    logic       pin_latch;
    logic       pin_reset;
  } pin_status_t;

  // one directed stimulus row, repeated reps times
  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [1:0]  rate;
    logic [7:0]  reps;
    logic        typed;
    pin_status_t status;
  } dir_row_t;

  function automatic pin_status_t mk_status(logic rst, logic lat, logic ck, logic dat,
                                            logic [2:0] sel, logic busy, logic done,
                                            logic err);
    pin_status_t s;
    s = '0;
    s.pin_reset  = rst;
    s.pin_latch  = lat;
    s.pin_clock  = ck;
    s.pin_data   = dat;
    s.sel        = sel;
    s.busy_res   = busy;
    s.done_res   = done;
    s.rate_error = err;
    return s;
  endfunction

  localparam pin_status_t ST_IDLE = mk_status(1'b1, 1'b1, 1'b1, 1'b1, 3'd0,
                                              1'b0, 1'b0, 1'b0);

  // rows from FIRST_SHORT_ROW on run with short delays
  localparam int FIRST_SHORT_ROW = 2;
  localparam int DIR_ROWS_N      = 17;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{ACT_TICK,  3'd0, RATE_32K,  8'd3,  1'b1, ST_IDLE},
    '{ACT_NONE,  3'd7, RATE_BAD,  8'd1,  1'b1, ST_IDLE},
    // unsupported rate: all pins low, error raised at once
    '{ACT_START, 3'd7, RATE_BAD,  8'd1,  1'b1,
      mk_status(1'b0, 1'b0, 1'b0, 1'b0, 3'd7, 1'b1, 1'b0, 1'b1)},
    // commands while busy are plain ticks
    '{ACT_START, 3'd2, RATE_32K,  8'd1,  1'b0, ST_IDLE},
    '{ACT_RESET, 3'd5, RATE_44K1, 8'd1,  1'b0, ST_IDLE},
    '{ACT_NONE,  3'd3, RATE_48K,  8'd1,  1'b0, ST_IDLE},
    '{ACT_TICK,  3'd7, RATE_BAD,  8'd60, 1'b0, ST_IDLE},
    // reset only: other pins kept, error flag left set
    '{ACT_RESET, 3'd5, RATE_32K,  8'd1,  1'b1,
      mk_status(1'b0, 1'b1, 1'b1, 1'b1, 3'd5, 1'b1, 1'b0, 1'b1)},
    '{ACT_TICK,  3'd0, RATE_32K,  8'd1,  1'b1,
      mk_status(1'b1, 1'b1, 1'b1, 1'b1, 3'd5, 1'b0, 1'b1, 1'b1)},
    '{ACT_START, 3'd0, RATE_32K,  8'd1,  1'b0, ST_IDLE},
    '{ACT_TICK,  3'd4, RATE_BAD,  8'd80, 1'b0, ST_IDLE},
    '{ACT_START, 3'd1, RATE_44K1, 8'd1,  1'b0, ST_IDLE},
    '{ACT_TICK,  3'd3, RATE_48K,  8'd80, 1'b0, ST_IDLE},
    '{ACT_START, 3'd6, RATE_48K,  8'd1,  1'b0, ST_IDLE},
    '{ACT_TICK,  3'd5, RATE_44K1, 8'd80, 1'b0, ST_IDLE},
    '{ACT_RESET, 3'd2, RATE_BAD,  8'd1,  1'b0, ST_IDLE},
    '{ACT_TICK,  3'd1, RATE_32K,  8'd2,  1'b0, ST_IDLE}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // [2:0] channel, [4:3] sample_rate
  logic [1:0]        in_tuser;   // [1:0] action
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [0] pin_reset, [1] pin_latch, [2] pin_clock,
                                 // [3] pin_data, [6:4] select, [7] busy_res,
                                 // [8] done_res, [9] rate_error

  audio_dac_serial_config_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor copy of registers and sequencer state
  cfg_regs_t               regs = '{RESET_LOW_DEF, RESET_WAIT_DEF, BIT_TICKS_DEF,
                                    LATCH_TICKS_DEF, RESET_PULSE_DEF};
  phase_t                  seq_ph    = PH_IDLE;
  logic [TICK_W-1:0]       seq_cnt   = '0;
  logic [BIT_IDX_W-1:0]    seq_bidx  = '0;
  logic [WORD_BITS-1:0]    seq_word  = '0;
  logic [3:0]              seq_pins  = PIN_ALL;
  logic [CHANNEL_BITS-1:0] seq_tgt   = '0;
  logic                    seq_pend  = 1'b0;
  logic [1:0]              seq_rcode = '0;
  logic                    seq_err   = 1'b0;

  pin_status_t pin_status_q[$];

  int fail_count = 0;
  int mism_count = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 71;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a zero delay lasts one tick
  function automatic logic [TICK_W-1:0] nonzero(logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // set clock low with the current data bit
  function automatic void shift_out_bit();
    seq_pins = PIN_RST | PIN_LAT | (seq_word[seq_bidx - 1'b1] ? PIN_DAT : PIN_NONE);
    seq_ph   = PH_BIT_LOW;
    seq_cnt  = nonzero(TICK_W'(regs.bit_ticks));
  endfunction

  function automatic void load_word(logic [WORD_BITS-1:0] w);
    seq_word = w;
    seq_bidx = BIT_IDX_W'(WORD_BITS);
    shift_out_bit();
  endfunction

  // advance the pin sequence by one accepted item
  function automatic pin_status_t predict_pins(in_item_t it);
    pin_status_t s;
    logic        fin;
    fin = 1'b0;
    if (seq_ph == PH_IDLE && it.action == ACT_START) begin
      seq_tgt = it.channel;
      case (it.rate)
        RATE_32K:  seq_rcode = 2'd2;
        RATE_44K1: seq_rcode = 2'd0;
        default:   seq_rcode = 2'd1;
      endcase
      seq_err  = (it.rate == RATE_BAD);
      seq_pend = !seq_err;
      seq_pins = PIN_NONE;
      seq_ph   = PH_LOW;
      seq_cnt  = nonzero(regs.reset_low_ticks);
    end else if (seq_ph == PH_IDLE && it.action == ACT_RESET) begin
      seq_tgt  = it.channel;
      seq_pins = seq_pins & ~PIN_RST;
      seq_ph   = PH_RSTP;
      seq_cnt  = nonzero(regs.reset_pulse_ticks);
    end else if (seq_ph != PH_IDLE) begin
      seq_cnt = seq_cnt - 1'b1;
      if (seq_cnt == '0) begin
        case (seq_ph)
          PH_LOW: begin
            seq_pins = PIN_ALL;
            seq_ph   = PH_WAIT;
            seq_cnt  = nonzero(regs.reset_wait_ticks);
          end
          PH_WAIT: load_word(FIRST_WORD);
          PH_BIT_LOW: begin
            seq_pins = seq_pins | PIN_CLK;
            seq_ph   = PH_BIT_HIGH;
            seq_cnt  = nonzero(TICK_W'(regs.bit_ticks));
          end
          PH_BIT_HIGH: begin
            seq_bidx = seq_bidx - 1'b1;
            if (seq_bidx != '0) begin
              shift_out_bit();
            end else begin
              seq_pins = (seq_pins | PIN_DAT) & ~PIN_LAT;
              seq_ph   = PH_LATCH;
              seq_cnt  = nonzero(TICK_W'(regs.latch_ticks));
            end
          end
          PH_LATCH: begin
            seq_pins = seq_pins | PIN_LAT;
            if (seq_pend) begin
              seq_pend = 1'b0;
              load_word(RATE_WORD | (WORD_BITS'(seq_rcode) << RATE_LSB));
            end else begin
              seq_ph = PH_IDLE;
              fin    = 1'b1;
            end
          end
          PH_RSTP: begin
            seq_pins = seq_pins | PIN_RST;
            seq_ph   = PH_IDLE;
            fin      = 1'b1;
          end
          default: seq_ph = PH_IDLE;
        endcase
      end
    end
    s = mk_status(seq_pins[0], seq_pins[1], seq_pins[2], seq_pins[3], seq_tgt,
                  seq_ph != PH_IDLE, fin, seq_err);
    return s;
  endfunction

  // offer one item, wait for its transfer, queue what it should produce
  task automatic send_item(in_item_t it, logic typed, pin_status_t typed_status);
    pin_status_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.rate, it.channel};
    in_tuser  <= it.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_pins(it);
    pin_status_q.push_back(typed ? typed_status : p);
  endtask

  // tick until the sequence is over and every result has arrived
  task automatic settle_idle();
    in_item_t tick;
    tick = '{ACT_TICK, 3'd0, RATE_32K};
    while (seq_ph != PH_IDLE) send_item(tick, 1'b0, ST_IDLE);
    in_tvalid <= 1'b0;
    while (pin_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      REG_RESET_LOW:   regs.reset_low_ticks   = val;
      REG_RESET_WAIT:  regs.reset_wait_ticks  = val;
      REG_BIT_TICKS:   regs.bit_ticks         = val[SHORT_W-1:0];
      REG_LATCH_TICKS: regs.latch_ticks       = val[SHORT_W-1:0];
      REG_RESET_PULSE: regs.reset_pulse_ticks = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CFG_W-1:0] low, logic [CFG_W-1:0] wait_t,
                              logic [CFG_W-1:0] bit_t, logic [CFG_W-1:0] latch,
                              logic [CFG_W-1:0] pulse);
    write_reg(REG_RESET_LOW, low);
    write_reg(REG_RESET_WAIT, wait_t);
    write_reg(REG_BIT_TICKS, bit_t);
    write_reg(REG_LATCH_TICKS, latch);
    write_reg(REG_RESET_PULSE, pulse);
    cfg_we <= 1'b0;
  endtask

  // mostly ticks with random content, commands now and then
  task automatic run_random(int n, logic allow_start, int hold_at);
    in_item_t it;
    int       r;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_seq++;
      r          = $urandom_range(99);
      it.channel = 3'($urandom_range(7));
      it.rate    = 2'($urandom_range(3));
      if (r < 8 && allow_start) it.action = ACT_START;
      else if (r >= 8 && r < 14) it.action = ACT_RESET;
      else if (r >= 14 && r < 20) it.action = ACT_NONE;
      else it.action = ACT_TICK;
      send_item(it, 1'b0, ST_IDLE);
    end
  endtask

  // result receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pin_status_t got;
    pin_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = pin_status_t'(out_tdata);
      if (pin_status_q.size() == 0) begin
        fail_count++;
        if (mism_count < MAX_REPORTS)
          $display("unexpected result %h with nothing pending", out_tdata);
        mism_count++;
      end else begin
        want = pin_status_q.pop_front();
        if (got.pad !== want.pad || got.rate_error !== want.rate_error ||
            got.done_res !== want.done_res || got.busy_res !== want.busy_res ||
            got.sel !== want.sel || got.pin_data !== want.pin_data ||
            got.pin_clock !== want.pin_clock || got.pin_latch !== want.pin_latch ||
            got.pin_reset !== want.pin_reset) begin
          fail_count++;
          if (mism_count < MAX_REPORTS)
            $display("mismatch: rst/lat/clk/dat exp %b%b%b%b got %b%b%b%b, ",
                     want.pin_reset, want.pin_latch, want.pin_clock, want.pin_data,
                     got.pin_reset, got.pin_latch, got.pin_clock, got.pin_data,
                     "sel exp %0d got %0d, busy exp %b got %b, ",
                     want.sel, got.sel, want.busy_res, got.busy_res,
                     "done exp %b got %b, err exp %b got %b, pad exp %h got %h",
                     want.done_res, got.done_res, want.rate_error, got.rate_error,
                     want.pad, got.pad);
          mism_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_TICK;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, short delays from the first command on
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      if (i == FIRST_SHORT_ROW) begin
        settle_idle();
        program_regs(24'd2, 24'd1, 24'd1, 24'd1, 24'd1);
      end
      it = '{DIR_ROWS[i].action, DIR_ROWS[i].channel, DIR_ROWS[i].rate};
      for (int j = 0; j < DIR_ROWS[i].reps; j++)
        send_item(it, DIR_ROWS[i].typed, DIR_ROWS[i].status);
    end

    // sender idles lightly, receiver heavily
    settle_idle();
    program_regs(24'd3, 24'd2, 24'd1, 24'd2, 24'd3);
    run_random(RANDOM_ITEMS, 1'b1, 100);

    // zero delays, upper bits set on the short registers
    settle_idle();
    send_idle_pct = 71;
    recv_idle_pct = 21;
    program_regs(24'd0, 24'd0, 24'hFF0000, 24'hAB0000, 24'd0);
    run_random(RANDOM_ITEMS, 1'b1, -1);

    // no idling on either side
    settle_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(24'd1, 24'd7, 24'd2, 24'd3, 24'd5);
    run_random(RANDOM_ITEMS, 1'b1, 150);

    // register maxima but a short reset pulse, only reset pulses are run
    settle_idle();
    program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd2);
    run_random(RANDOM_ITEMS, 1'b0, -1);

    settle_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pin_status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
